// File: rtl/acp_pkg.sv
// Shared types, character constants and command table for the command parser.
package acp_pkg;

  // Characters the parser looks for
  localparam logic [7:0] CH_START   = 8'h61;  // 'a'
  localparam logic [7:0] CH_A       = 8'h41;
  localparam logic [7:0] CH_Z       = 8'h5A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] ADDR_RESET = 8'h2A;  // '*', a wildcard

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  // Register map, indexed by paddr[3:2]
  localparam int          ADDR_W         = 4;
  localparam logic [1:0]  REG_ADDR_FIRST  = 2'd0;
  localparam logic [1:0]  REG_ADDR_SECOND = 2'd1;
  localparam logic [1:0]  REG_TIMEOUT     = 2'd2;

  // Long commands may fill the store except for header and one spare byte
  localparam int LIMIT_LONG_OFFSET = 6;

  localparam int NUM_CMDS = 12;

  typedef enum logic [3:0] {
    CMD_CD = 4'd0,
    CMD_CL = 4'd1,
    CMD_DC = 4'd2,
    CMD_ID = 4'd3,
    CMD_MP = 4'd4,
    CMD_P  = 4'd5,
    CMD_ST = 4'd6,
    CMD_TC = 4'd7,
    CMD_TE = 4'd8,
    CMD_TI = 4'd9,
    CMD_V  = 4'd10,
    CMD_WN = 4'd11
  } cmd_t;

  // Letters of each code; a zero second letter marks a one-letter code
  localparam logic [7:0] CMD_FIRST [NUM_CMDS] = '{
    8'h43, 8'h43, 8'h44, 8'h49, 8'h4D, 8'h50, 8'h53, 8'h54, 8'h54, 8'h54, 8'h56, 8'h57
  };
  localparam logic [7:0] CMD_SECOND [NUM_CMDS] = '{
    8'h44, 8'h4C, 8'h43, 8'h44, 8'h50, 8'h00, 8'h54, 8'h43, 8'h45, 8'h49, 8'h00, 8'h4E
  };

  typedef struct packed {
    logic hit;
    cmd_t code;
  } cmd_hit_t;

  // Fixed part of a finished frame handed from front to back
  typedef struct packed {
    logic       bank;
    cmd_t       cmd;
    logic [2:0] start;
  } frame_hdr_t;

  // Back end frees a store bank once its last result is taken in
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  function automatic logic is_wild(input logic [7:0] a);
    is_wild = (a < CH_A) || (a > CH_Z);
  endfunction

  function automatic cmd_hit_t cmd_lookup(input logic [7:0] first, input logic [7:0] second);
    cmd_hit_t r;
    r = '{hit: 1'b0, code: CMD_CD};
    for (int i = NUM_CMDS - 1; i >= 0; i--) begin
      if (CMD_FIRST[i] == first && CMD_SECOND[i] == second) begin
        r.hit  = 1'b1;
        r.code = cmd_t'(4'(i));
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/acp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module acp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/acp_fifo.sv
// Two-entry queue of finished frame descriptors between front and back.
module acp_fifo
  import acp_pkg::*;
#(
  parameter int WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output fifo_stat_t       stat
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign stat.empty = (count == 2'd0);
  assign stat.full  = (count == 2'd2);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = slots[rd_ptr];

  // Slot storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/acp_front.sv
// Front end: takes bytes and ticks, checks the header, stores the frame, queues it.
module acp_front
  import acp_pkg::*;
#(
  parameter int FRAME_LEN = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_tick,
  input  logic [7:0]                     in_byte,
  input  logic [7:0]                     addr_first,
  input  logic [7:0]                     addr_second,
  input  logic [15:0]                    timeout_ticks,
  input  bank_rel_t                      rel,
  output logic                           wr_en,
  output logic [$clog2(FRAME_LEN):0]     wr_addr,
  output logic [7:0]                     wr_data,
  output logic                           push,
  output frame_hdr_t                     push_hdr,
  output logic [$clog2(FRAME_LEN+1)-1:0] push_count
);

  localparam int FW = $clog2(FRAME_LEN + 1);
  localparam int IW = $clog2(FRAME_LEN);

  logic [FW-1:0] fill_count,    fill_next;
  cmd_t          command_code,  code_next;
  logic          command_known, known_next;
  logic [2:0]    payload_start, start_next;
  logic [15:0]   elapsed_ticks, elapsed_next;
  logic          timer_armed,   armed_next;
  logic [7:0]    first_letter,  first_next;
  logic          bank,          bank_next;
  logic [1:0]    busy,          busy_next;

  logic          accept;
  logic          clr;
  logic          fire;
  cmd_hit_t      hit;

  // Payload length at which each command completes
  function automatic logic [FW-1:0] limit_of(input cmd_t c);
    case (c)
      CMD_CD:  limit_of = FW'(1);
      CMD_CL:  limit_of = FW'(0);
      CMD_DC:  limit_of = FW'(0);
      CMD_ID:  limit_of = FW'(2);
      CMD_MP:  limit_of = FW'(4);
      CMD_P:   limit_of = FW'(5);
      CMD_ST:  limit_of = FW'(FRAME_LEN - LIMIT_LONG_OFFSET);
      CMD_TC:  limit_of = FW'(2);
      CMD_TE:  limit_of = FW'(FRAME_LEN - LIMIT_LONG_OFFSET);
      CMD_TI:  limit_of = FW'(4);
      CMD_V:   limit_of = FW'(8);
      CMD_WN:  limit_of = FW'(1);
      default: limit_of = FW'(0);
    endcase
  endfunction

  // Stall while the bank being filled is still draining
  assign in_ready = !busy[bank];
  assign accept   = in_valid && in_ready;
  assign wr_data  = in_byte;
  assign wr_addr  = {bank, fill_count[IW-1:0]};

  // Parse one beat
  always_comb begin
    fill_next    = fill_count;
    code_next    = command_code;
    known_next   = command_known;
    start_next   = payload_start;
    elapsed_next = elapsed_ticks;
    armed_next   = timer_armed;
    first_next   = first_letter;
    bank_next    = bank;
    busy_next    = busy;
    wr_en        = 1'b0;
    clr          = 1'b0;
    fire         = 1'b0;
    push         = 1'b0;
    hit          = '{hit: 1'b0, code: CMD_CD};
    push_hdr     = '{bank: bank, cmd: command_code, start: payload_start};
    push_count   = fill_count;

    if (accept && in_tick) begin
      // Frame timeout
      if (timer_armed && fill_count != '0) begin
        if (elapsed_ticks >= timeout_ticks) begin
          clr = 1'b1;
        end else begin
          elapsed_next = elapsed_ticks + 16'd1;
        end
      end
    end else if (accept) begin
      if (in_byte == CH_CR || in_byte == CH_LF) begin
        fire = 1'b1;
      end else if (fill_count >= FW'(FRAME_LEN)) begin
        clr = 1'b1;
      end else begin
        wr_en     = 1'b1;
        fill_next = fill_count + FW'(1);
        if (fill_count == FW'(0)) begin
          if (in_byte != CH_START) begin
            clr = 1'b1;
          end else begin
            armed_next   = 1'b1;
            elapsed_next = '0;
          end
        end else if (fill_count == FW'(1)) begin
          if (!is_wild(addr_first) && in_byte != addr_first) clr = 1'b1;
        end else if (fill_count == FW'(2)) begin
          if (!is_wild(addr_second) && in_byte != addr_second) clr = 1'b1;
        end else if (fill_count == FW'(3)) begin
          // One-letter codes
          first_next = in_byte;
          hit        = cmd_lookup(in_byte, 8'h00);
          if (hit.hit) begin
            code_next  = hit.code;
            known_next = 1'b1;
            start_next = 3'd4;
          end
        end else if (fill_count == FW'(4) && !command_known) begin
          // Two-letter codes
          if (first_letter != 8'h00 && in_byte != 8'h00) begin
            hit = cmd_lookup(first_letter, in_byte);
          end
          if (hit.hit) begin
            code_next  = hit.code;
            known_next = 1'b1;
            start_next = 3'd5;
          end else begin
            clr = 1'b1;
          end
        end

        // Completion on full store or payload limit
        if (!clr) begin
          if (fill_next >= FW'(FRAME_LEN)) fire = 1'b1;
          if (known_next && fill_next >= FW'(start_next) &&
              (fill_next - FW'(start_next)) >= limit_of(code_next)) begin
            fire = 1'b1;
          end
        end
      end
    end

    // Hand a finished frame to the back end
    if (fire) begin
      push       = known_next;
      push_hdr   = '{bank: bank, cmd: code_next, start: start_next};
      push_count = fill_next;
      clr        = 1'b1;
    end
    if (push) begin
      busy_next[bank] = 1'b1;
      bank_next       = ~bank;
    end
    if (rel.valid) begin
      busy_next[rel.bank] = 1'b0;
    end

    if (clr) begin
      fill_next    = '0;
      code_next    = CMD_CD;
      known_next   = 1'b0;
      start_next   = 3'd0;
      elapsed_next = '0;
      armed_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count    <= '0;
      command_code  <= CMD_CD;
      command_known <= 1'b0;
      payload_start <= 3'd0;
      elapsed_ticks <= '0;
      timer_armed   <= 1'b0;
      bank          <= 1'b0;
      busy          <= 2'b00;
    end else begin
      fill_count    <= fill_next;
      command_code  <= code_next;
      command_known <= known_next;
      payload_start <= start_next;
      elapsed_ticks <= elapsed_next;
      timer_armed   <= armed_next;
      bank          <= bank_next;
      busy          <= busy_next;
    end
  end

  // Command letter, only read after it is written in the same frame
  always_ff @(posedge clk) begin
    first_letter <= first_next;
  end

endmodule

// File: rtl/acp_back.sv
// Back end: pops frame descriptors and drains payload bytes as result beats.
module acp_back
  import acp_pkg::*;
#(
  parameter int FRAME_LEN = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  fifo_stat_t                     q_stat,
  input  frame_hdr_t                     q_hdr,
  input  logic [$clog2(FRAME_LEN+1)-1:0] q_count,
  output logic                           pop,
  output logic                           rd_en,
  output logic [$clog2(FRAME_LEN):0]     rd_addr,
  input  logic [7:0]                     rd_data,
  output bank_rel_t                      rel,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [3:0]                     out_cmd,
  output logic [7:0]                     out_data,
  output logic                           out_has_data,
  output logic                           out_last
);

  localparam int FW = $clog2(FRAME_LEN + 1);
  localparam int IW = $clog2(FRAME_LEN);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_LOAD = 3'b100
  } state_t;

  state_t        state, state_next;
  frame_hdr_t    hdr;
  logic [FW-1:0] count;
  logic [FW-1:0] ptr;
  logic          empty;
  logic          out_free;
  logic          load;
  logic          is_last;

  assign out_free = !out_valid || out_ready;
  assign pop      = (state == ST_IDLE) && !q_stat.empty;
  assign rd_en    = (state == ST_READ);
  assign rd_addr  = {hdr.bank, ptr[IW-1:0]};
  assign load     = (state == ST_LOAD) && out_free;
  assign is_last  = empty || (ptr + FW'(1) == count);
  assign rel      = '{valid: load && is_last, bank: hdr.bank};

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          state_next = (q_count <= FW'(q_hdr.start)) ? ST_LOAD : ST_READ;
        end
      end
      ST_READ: state_next = ST_LOAD;
      ST_LOAD: begin
        if (out_free) state_next = is_last ? ST_IDLE : ST_READ;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Frame being drained
  always_ff @(posedge clk) begin
    if (pop) begin
      hdr   <= q_hdr;
      count <= q_count;
      ptr   <= FW'(q_hdr.start);
      empty <= (q_count <= FW'(q_hdr.start));
    end else if (load) begin
      ptr <= ptr + FW'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load) begin
      out_cmd      <= hdr.cmd;
      out_data     <= empty ? 8'h00 : rd_data;
      out_has_data <= !empty;
      out_last     <= is_last;
    end
  end

endmodule

// File: rtl/addressed_serial_command_parser.sv
// Top level: configuration registers, front end, descriptor queue, frame store, back end.
// Input beats carry a received byte (tuser 0) or one time tick (tuser 1); the front end
// takes one beat per cycle and answers a frame with a run of result beats, one per payload
// byte or one empty beat (tuser 0), tlast on the final one. The frame store has two banks of
// FRAME_LEN bytes, so one frame can drain while the next arrives; input stalls only when
// the bank it would fill still holds a frame not yet drained. The back end makes each
// result beat from a store read and then a load of the output register, stalling while the
// receiver holds off; it pops the next frame only once the last beat of one is loaded.
module addressed_serial_command_parser
  import acp_pkg::*;
#(
  parameter int FRAME_LEN = 32
) (
  input  logic              clk,
  input  logic              rst,
  // Input stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] rx_byte
  input  logic              s_tuser,   // [0] opcode
  // Result stream
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [15:0]       m_tdata,   // [3:0] command, [11:4] data_byte, [15:12] zero
  output logic              m_tuser,   // [0] has_data
  output logic              m_tlast,
  // Configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int FW = $clog2(FRAME_LEN + 1);
  localparam int AW = $clog2(FRAME_LEN) + 1;
  localparam int QW = $bits(frame_hdr_t) + FW;

  logic [7:0]    addr_first;
  logic [7:0]    addr_second;
  logic [15:0]   timeout_ticks;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  logic          push;
  frame_hdr_t    push_hdr;
  logic [FW-1:0] push_count;
  logic          pop;
  logic [QW-1:0] q_head;
  fifo_stat_t    q_stat;
  frame_hdr_t    q_hdr;
  logic [FW-1:0] q_count;
  bank_rel_t     rel;

  logic [3:0]    out_cmd;
  logic [7:0]    out_data;

  // Configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      addr_first    <= ADDR_RESET;
      addr_second   <= ADDR_RESET;
      timeout_ticks <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_ADDR_FIRST:  addr_first    <= pwdata[7:0];
        REG_ADDR_SECOND: addr_second   <= pwdata[7:0];
        REG_TIMEOUT:     timeout_ticks <= pwdata[15:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ADDR_FIRST:  prdata = {24'h0, addr_first};
      REG_ADDR_SECOND: prdata = {24'h0, addr_second};
      REG_TIMEOUT:     prdata = {16'h0, timeout_ticks};
      default:         prdata = '0;
    endcase
  end

  acp_front #(
    .FRAME_LEN(FRAME_LEN)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_tick      (s_tuser),
    .in_byte      (s_tdata),
    .addr_first   (addr_first),
    .addr_second  (addr_second),
    .timeout_ticks(timeout_ticks),
    .rel          (rel),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .push         (push),
    .push_hdr     (push_hdr),
    .push_count   (push_count)
  );

  acp_fifo #(
    .WIDTH(QW)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data({push_hdr, push_count}),
    .pop      (pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  assign q_hdr   = frame_hdr_t'(q_head[QW-1:FW]);
  assign q_count = q_head[FW-1:0];

  acp_ram #(
    .WIDTH(8),
    .DEPTH(2 ** AW)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  acp_back #(
    .FRAME_LEN(FRAME_LEN)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_stat      (q_stat),
    .q_hdr       (q_hdr),
    .q_count     (q_count),
    .pop         (pop),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .rel         (rel),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_cmd     (out_cmd),
    .out_data    (out_data),
    .out_has_data(m_tuser),
    .out_last    (m_tlast)
  );

  assign m_tdata = {4'h0, out_data, out_cmd};

  // A finished frame always finds room in the queue
  a_queue_room: assert property (@(posedge clk) disable iff (rst) push |-> !q_stat.full)
    else $error("descriptor queue overflow");

  // An empty-payload beat is a whole run on its own
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tlast && m_tdata[11:4] == 8'h00))
    else $error("empty payload beat not final or carries data");

  // The bank being drained is never the one written
  a_bank_split: assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (wr_addr[AW-1] != rd_addr[AW-1]))
    else $error("front and back end share a store bank");

endmodule

// File: bench/addressed_serial_command_parser_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the addressed serial command parser: directed and random frames.
module addressed_serial_command_parser_tb;
  import acp_pkg::*;

  localparam int FRAME_LEN    = 32;
  localparam int DRAIN_CYCLES = 2 * FRAME_LEN + 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int LIMIT_NS     = 2_000_000;

  // Input beat kinds carried on s_tuser
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Letters of each command, low byte zero for one-letter codes
  localparam logic [15:0] CODE_LETTERS [NUM_CMDS] = '{
    "CD", "CL", "DC", "ID", "MP", {"P", 8'h00}, "ST", "TC", "TE", "TI", {"V", 8'h00}, "WN"
  };

  typedef struct packed {
    cmd_t       command;
    logic [7:0] data_byte;
    logic       has_data;
    logic       is_last;
  } result_t;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata  = 8'h00;
  logic              s_tuser  = OP_BYTE;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [15:0]       m_tdata;
  logic              m_tuser;
  logic              m_tlast;
  logic              psel     = 1'b0;
  logic              penable  = 1'b0;
  logic              pwrite   = 1'b0;
  logic [ADDR_W-1:0] paddr    = '0;
  logic [31:0]       pwdata   = 32'h0;
  logic [31:0]       prdata;
  logic              pready;

  // Stimulus knobs
  int   send_gap_pct = 0;
  int   recv_gap_pct = 0;
  int   tick_pct     = 0;
  int   beats_used   = 0;
  int   err_count    = 0;
  logic stall_all    = 1'b0;
  event start_hold;

  // Predicted register contents
  logic [7:0]  cfg_first   = ADDR_RESET;
  logic [7:0]  cfg_second  = ADDR_RESET;
  logic [15:0] cfg_timeout = TIMEOUT_RESET;

  // Predicted frame state
  logic [7:0]  frm_bytes [FRAME_LEN];
  int          frm_fill  = 0;
  int          frm_start = 0;
  cmd_t        frm_code  = CMD_CD;
  bit          frm_known = 1'b0;
  logic [15:0] frm_ticks = 16'h0;
  bit          frm_armed = 1'b0;

  result_t pending_results [$];

  addressed_serial_command_parser #(.FRAME_LEN(FRAME_LEN)) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit addr_is_any(input logic [7:0] c);
    return (c < CH_A) || (c > CH_Z);
  endfunction

  function automatic int payload_limit(input cmd_t code);
    case (code)
      CMD_CD, CMD_WN:          return 1;
      CMD_CL, CMD_DC:          return 0;
      CMD_ID, CMD_TC:          return 2;
      CMD_MP, CMD_TI:          return 4;
      CMD_P:                   return 5;
      CMD_V:                   return 8;
      default:                 return FRAME_LEN - 6;  // ST, TE
    endcase
  endfunction

  function automatic bit decode_cmd(input logic [7:0] c1, input logic [7:0] c2,
                                    output cmd_t code);
    code = CMD_CD;
    for (int i = 0; i < NUM_CMDS; i++) begin
      if (CODE_LETTERS[i] == {c1, c2}) begin
        code = cmd_t'(4'(i));
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void drop_frame();
    frm_fill  = 0;
    frm_start = 0;
    frm_code  = CMD_CD;
    frm_known = 1'b0;
    frm_ticks = 16'h0;
    frm_armed = 1'b0;
  endfunction

  // Queue the run a finished frame produces: one beat per payload byte, or one empty beat
  function automatic void queue_run();
    if (!frm_known) return;
    if (frm_fill <= frm_start) begin
      pending_results.push_back('{frm_code, 8'h00, 1'b0, 1'b1});
    end else begin
      for (int i = frm_start; i < frm_fill; i++)
        pending_results.push_back('{frm_code, frm_bytes[i], 1'b1, (i + 1 == frm_fill)});
    end
  endfunction

  // Advance the frame state by one accepted input beat
  function automatic void parse_beat(input logic op, input logic [7:0] b);
    int   pos;
    bit   done;
    cmd_t code;
    done = 1'b0;
    if (op == OP_TICK) begin
      if (frm_armed && frm_fill > 0) begin
        if (frm_ticks >= cfg_timeout) drop_frame();
        else frm_ticks = frm_ticks + 16'd1;
      end
      return;
    end
    if (b == CH_CR || b == CH_LF) begin
      done = 1'b1;
    end else begin
      pos = frm_fill;
      if (pos >= FRAME_LEN) begin
        drop_frame();
        return;
      end
      frm_bytes[pos] = b;
      frm_fill = pos + 1;
      case (pos)
        0: begin
          if (b != CH_START) begin
            drop_frame();
          end else begin
            frm_armed = 1'b1;
            frm_ticks = 16'h0;
          end
        end
        1: if (!addr_is_any(cfg_first) && b != cfg_first) drop_frame();
        2: if (!addr_is_any(cfg_second) && b != cfg_second) drop_frame();
        3: begin
          if (decode_cmd(b, 8'h00, code)) begin
            frm_code  = code;
            frm_known = 1'b1;
            frm_start = 4;
          end
        end
        4: begin
          if (!frm_known) begin
            if (frm_bytes[3] != 8'h00 && b != 8'h00 && decode_cmd(frm_bytes[3], b, code)) begin
              frm_code  = code;
              frm_known = 1'b1;
              frm_start = 5;
            end else begin
              drop_frame();
            end
          end
        end
        default: ;
      endcase
    end
    if (frm_fill >= FRAME_LEN) done = 1'b1;
    if (frm_known && frm_fill >= frm_start && frm_fill - frm_start >= payload_limit(frm_code))
      done = 1'b1;
    if (done) begin
      queue_run();
      drop_frame();
    end
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    err_count++;
  endtask

  // Compare every accepted result beat with the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat with none expected, tdata %h", m_tdata));
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[3:0] !== want.command)
          report_mismatch($sformatf("command %0d, expected %0d", m_tdata[3:0], want.command));
        if (m_tdata[11:4] !== want.data_byte)
          report_mismatch($sformatf("data_byte %h, expected %h", m_tdata[11:4], want.data_byte));
        if (m_tdata[15:12] !== 4'h0)
          report_mismatch($sformatf("tdata pad bits %h", m_tdata[15:12]));
        if (m_tuser !== want.has_data)
          report_mismatch($sformatf("has_data %b, expected %b", m_tuser, want.has_data));
        if (m_tlast !== want.is_last)
          report_mismatch($sformatf("tlast %b, expected %b", m_tlast, want.is_last));
      end
    end
  end

  // ---------------------------------------------------------------- result side

  // Random stalls on the result side, forced low during a long hold
  always @(posedge clk) begin
    m_tready <= !rst && !stall_all && ($urandom_range(99) >= recv_gap_pct);
  end

  // Long receiver hold so the store banks fill and the input stalls
  initial begin
    forever begin
      @(start_hold);
      stall_all <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      stall_all <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- drivers

  // One input beat; s_tvalid stays high when the next beat follows at once
  task automatic send_beat(input logic op, input logic [7:0] b);
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (op == OP_BYTE || (frm_armed && frm_fill > 0)) beats_used++;
    parse_beat(op, b);
  endtask

  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < tick_pct) send_beat(OP_TICK, 8'($urandom));
    send_beat(OP_BYTE, b);
  endtask

  // Setup and access phase, then the bus returns to idle
  task automatic apb_access(input logic write, input logic [1:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic verify_reg(input logic [1:0] idx);
    logic [31:0] want;
    logic [31:0] got;
    case (idx)
      REG_ADDR_FIRST:  want = {24'h0, cfg_first};
      REG_ADDR_SECOND: want = {24'h0, cfg_second};
      default:         want = {16'h0, cfg_timeout};
    endcase
    apb_access(1'b0, idx, 32'h0, got);
    if (got !== want)
      report_mismatch($sformatf("register %0d reads %h, expected %h", idx, got, want));
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] unused;
    apb_access(1'b1, idx, val, unused);
    case (idx)
      REG_ADDR_FIRST:  cfg_first   = val[7:0];
      REG_ADDR_SECOND: cfg_second  = val[7:0];
      default:         cfg_timeout = val[15:0];
    endcase
    verify_reg(idx);
  endtask

  // Close any partial frame, then wait until the block has drained
  task automatic end_phase();
    send_beat(OP_BYTE, CH_LF);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- frame builders

  function automatic logic [7:0] addr_pick(input logic [7:0] cfg);
    if (addr_is_any(cfg)) return 8'($urandom);
    return cfg;
  endfunction

  task automatic send_frame(input logic [7:0] a1, input logic [7:0] a2, input cmd_t code,
                            input int n, input bit close);
    logic [15:0] letters;
    letters = CODE_LETTERS[code];
    send_byte(CH_START);
    send_byte(a1);
    send_byte(a2);
    send_byte(letters[15:8]);
    if (letters[7:0] != 8'h00) send_byte(letters[7:0]);
    repeat (n) send_byte(8'($urandom));
    if (close && n < payload_limit(code)) send_byte($urandom_range(1) ? CH_CR : CH_LF);
  endtask

  // Mostly well-formed frames, some cut-off headers, some raw noise
  task automatic send_random_frame();
    int         kind;
    int         lim;
    int         n;
    cmd_t       code;
    logic [7:0] a1;
    logic [7:0] a2;
    kind = $urandom_range(99);
    code = cmd_t'(4'($urandom_range(NUM_CMDS - 1)));
    lim  = payload_limit(code);
    if (kind < 80) begin
      a1 = ($urandom_range(11) == 0) ? 8'($urandom_range(CH_Z, CH_A)) : addr_pick(cfg_first);
      a2 = ($urandom_range(11) == 0) ? 8'($urandom_range(CH_Z, CH_A)) : addr_pick(cfg_second);
      n  = ($urandom_range(7) == 0) ? lim : $urandom_range(lim < 6 ? lim : 6);
      send_frame(a1, a2, code, n, 1'b1);
    end else if (kind < 92) begin
      send_byte(CH_START);
      repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
    end else begin
      repeat ($urandom_range(3, 1)) send_beat(1'($urandom), 8'($urandom));
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_register_reset();
    verify_reg(REG_ADDR_FIRST);
    verify_reg(REG_ADDR_SECOND);
    verify_reg(REG_TIMEOUT);
  endtask

  // Every command once; long command at its full payload
  task automatic test_each_command();
    int n;
    for (int i = 0; i < NUM_CMDS; i++) begin
      n = payload_limit(cmd_t'(4'(i)));
      if (i != CMD_ST && n > 2) n = 2;
      send_frame("Q", "R", cmd_t'(4'(i)), n, 1'b1);
    end
    // one-letter code closed at once gives an empty beat
    send_frame("Q", "R", CMD_P, 0, 1'b1);
    // payload byte extremes
    send_byte(CH_START);
    send_byte("Q");
    send_byte("R");
    send_byte("V");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_CR);
    end_phase();
  endtask

  task automatic test_bad_frames();
    // no start letter
    send_byte("b");
    send_byte(CH_CR);
    // unknown one-letter and two-letter code
    send_byte(CH_START);
    send_byte("Q");
    send_byte("R");
    send_byte("X");
    send_byte("Y");
    // zero as second code letter
    send_byte(CH_START);
    send_byte("Q");
    send_byte("R");
    send_byte("C");
    send_byte(8'h00);
    // terminator before the command is known
    send_byte(CH_START);
    send_byte("Q");
    send_byte(CH_CR);
    // ticks with no frame open
    send_beat(OP_TICK, 8'hFF);
    send_beat(OP_TICK, 8'h00);
    // parser recovers
    send_frame("Q", "R", CMD_TC, 2, 1'b1);
    end_phase();
  endtask

  task automatic test_address_match();
    set_reg(REG_ADDR_FIRST, 32'("A"));
    set_reg(REG_ADDR_SECOND, 32'("Z"));
    send_frame("A", "Z", CMD_ID, 1, 1'b1);
    send_frame("B", "Z", CMD_ID, 1, 1'b1);
    send_frame("A", "Y", CMD_ID, 1, 1'b1);
    end_phase();
    // wildcards far below and far above the letter range
    set_reg(REG_ADDR_FIRST, 32'h00);
    set_reg(REG_ADDR_SECOND, 32'hFF);
    send_frame(8'h00, 8'hFF, CMD_WN, 1, 1'b1);
    send_frame("@", "[", CMD_MP, 2, 1'b1);
    end_phase();
  endtask

  task automatic test_timeout();
    set_reg(REG_TIMEOUT, 32'd1);
    // second tick expires the frame, the rest is noise
    send_frame("Q", "R", CMD_ST, 1, 1'b0);
    send_beat(OP_TICK, 8'h5A);
    send_beat(OP_TICK, 8'hA5);
    send_byte(8'h55);
    send_byte(CH_CR);
    // one tick stays within the limit
    send_frame("Q", "R", CMD_TE, 1, 1'b0);
    send_beat(OP_TICK, 8'h00);
    send_byte(CH_LF);
    end_phase();
    set_reg(REG_TIMEOUT, 32'd65535);
    send_frame("Q", "R", CMD_V, 2, 1'b0);
    repeat (3) send_beat(OP_TICK, 8'($urandom));
    send_byte(CH_CR);
    end_phase();
  endtask

  task automatic test_random(input int snd_pct, input int rcv_pct, input int beats,
                             input logic [7:0] first, input logic [7:0] second,
                             input logic [15:0] limit_ticks, input int ticks_pct);
    int target;
    set_reg(REG_ADDR_FIRST, 32'(first));
    set_reg(REG_ADDR_SECOND, 32'(second));
    set_reg(REG_TIMEOUT, 32'(limit_ticks));
    send_gap_pct = snd_pct;
    recv_gap_pct = rcv_pct;
    tick_pct     = ticks_pct;
    target       = beats_used + beats;
    while (beats_used < target) send_random_frame();
    tick_pct = 0;
    end_phase();
  endtask

  // Receiver holds off while frames keep arriving
  task automatic test_backpressure();
    send_gap_pct = 0;
    recv_gap_pct = 0;
    -> start_hold;
    repeat (3) send_frame(addr_pick(cfg_first), addr_pick(cfg_second), CMD_TE, 6, 1'b1);
    end_phase();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_reset();
    send_gap_pct = 18;
    recv_gap_pct = 88;
    test_each_command();
    test_bad_frames();
    test_address_match();
    test_timeout();
    test_random(18, 88, 15, 8'($urandom_range(CH_Z, CH_A)), ADDR_RESET, TIMEOUT_RESET, 8);
    test_random(88, 18, 15, 8'($urandom_range(CH_Z, CH_A)), 8'($urandom_range(CH_Z, CH_A)),
                16'($urandom_range(6, 2)), 30);
    test_random(0, 0, 15, 8'($urandom_range(CH_A - 1)), 8'($urandom_range(CH_Z, CH_A)),
                16'($urandom_range(65535, 1)), 10);
    test_backpressure();
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(LIMIT_NS);
    $display("timeout: %0d results still expected", pending_results.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
